FILE: rtl/dwb_pkg.sv
package dwb_pkg;

    localparam int MAX_SIDE    = 32;
    localparam int PIXEL_BITS  = 16;
    localparam int FRAC_BITS   = 8;
    localparam int SCALE_FRAC  = 12;
    localparam int POS_W       = 5;
    localparam int SIDE_W      = 6;
    localparam int ADDR_W      = 10;
    localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int COORD_W     = POS_W + FRAC_BITS;
    localparam int WGT_W       = 2 * FRAC_BITS + 1;
    localparam int PROD_W      = PIXEL_BITS + 2 * FRAC_BITS;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SIDE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd1;

    localparam logic [SIDE_W-1:0] SIDE_RESET  = 6'd28;
    localparam logic [15:0]       SCALE_RESET = 16'd4096;
    localparam logic [SIDE_W-1:0] SIDE_MIN    = 6'd2;
    localparam logic [SIDE_W-1:0] SIDE_MAX    = 6'd32;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef struct packed {
        logic [POS_W-1:0]     idx;
        logic [FRAC_BITS-1:0] frac;
    } t_coord;

    typedef struct packed {
        logic [ADDR_W-1:0] ll;
        logic [ADDR_W-1:0] lh;
        logic [ADDR_W-1:0] hl;
        logic [ADDR_W-1:0] hh;
    } t_quad_addr;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] ll;
        logic [PIXEL_BITS-1:0] lh;
        logic [PIXEL_BITS-1:0] hl;
        logic [PIXEL_BITS-1:0] hh;
    } t_quad_pix;

    typedef struct packed {
        logic [WGT_W-1:0] ll;
        logic [WGT_W-1:0] lh;
        logic [WGT_W-1:0] hl;
        logic [WGT_W-1:0] hh;
    } t_quad_wgt;

endpackage

FILE: rtl/dwb_coord.sv
module dwb_coord
    import dwb_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [POS_W-1:0]        i_pos,
    input  logic signed [15:0]      i_disp,
    input  logic [15:0]             i_scale,
    input  logic [SIDE_W-1:0]       i_side,
    output t_coord                  o_coord
);

    logic signed [32:0]     r_prod;
    logic [POS_W-1:0]       r_pos;
    t_coord                 r_coord;

    logic signed [32:0]     n_prod;
    logic signed [32:0]     rnd;
    logic signed [20:0]     delta;
    logic signed [21:0]     pos_fx;
    logic signed [21:0]     coord;
    logic [POS_W-1:0]       side_m1;
    logic [COORD_W-1:0]     hi;
    t_coord                 n_coord;

    assign n_prod  = i_disp * $signed({1'b0, i_scale});
    assign rnd     = r_prod + 33'sd2048;
    assign delta   = rnd[32:SCALE_FRAC];
    assign pos_fx  = $signed({9'b0, r_pos, {FRAC_BITS{1'b0}}});
    assign coord   = pos_fx + {delta[20], delta};
    assign side_m1 = POS_W'(i_side - 6'd1);
    assign hi      = {side_m1, {FRAC_BITS{1'b0}}} - 13'd1;

    always_comb begin
        if (coord < 22'sd0) begin
            n_coord = '0;
        end else if (coord > $signed({9'b0, hi})) begin
            n_coord = hi;
        end else begin
            n_coord = coord[COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= n_prod;
            r_pos   <= i_pos;
            r_coord <= n_coord;
        end
    end

    assign o_coord = r_coord;

endmodule

FILE: rtl/dwb_store.sv
module dwb_store
    import dwb_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic                    i_we,
    input  logic [ADDR_W-1:0]       i_waddr,
    input  logic [PIXEL_BITS-1:0]   i_wdata,
    input  logic                    i_re,
    input  t_quad_addr              i_raddr,
    output t_quad_pix               o_pix
);

    logic [PIXEL_BITS-1:0] mem_lo [0:STORE_DEPTH-1];
    logic [PIXEL_BITS-1:0] mem_hi [0:STORE_DEPTH-1];
    t_quad_pix             r_pix;

    always_ff @(posedge i_clk) begin
        if (i_en && i_we) begin
            mem_lo[i_waddr] <= i_wdata;
            mem_hi[i_waddr] <= i_wdata;
        end
        if (i_en && i_re) begin
            r_pix.ll <= mem_lo[i_raddr.ll];
            r_pix.hl <= mem_lo[i_raddr.hl];
            r_pix.lh <= mem_hi[i_raddr.lh];
            r_pix.hh <= mem_hi[i_raddr.hh];
        end
    end

    assign o_pix = r_pix;

endmodule

FILE: rtl/dwb_blend.sv
module dwb_blend
    import dwb_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_en,
    input  t_quad_pix               i_pix,
    input  t_quad_wgt               i_wgt,
    output logic [PIXEL_BITS-1:0]   o_value
);

    logic [PROD_W-1:0]     r_p_ll;
    logic [PROD_W-1:0]     r_p_lh;
    logic [PROD_W-1:0]     r_p_hl;
    logic [PROD_W-1:0]     r_p_hh;
    logic [PIXEL_BITS-1:0] r_value;
    logic [PROD_W-1:0]     sum;

    assign sum = r_p_ll + r_p_lh + r_p_hl + r_p_hh
               + PROD_W'(1 << (2 * FRAC_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_ll  <= PROD_W'(i_pix.ll) * PROD_W'(i_wgt.ll);
            r_p_lh  <= PROD_W'(i_pix.lh) * PROD_W'(i_wgt.lh);
            r_p_hl  <= PROD_W'(i_pix.hl) * PROD_W'(i_wgt.hl);
            r_p_hh  <= PROD_W'(i_pix.hh) * PROD_W'(i_wgt.hh);
            r_value <= sum[PROD_W-1:2*FRAC_BITS];
        end
    end

    assign o_value = r_value;

endmodule

FILE: rtl/displacement_warp_bilinear_unit.sv
// Channel  | valid    | stall    | payload
// ---------+----------+----------+-------------------------------------------------
// input    | i_valid  | o_stall  | i_func i_load_address i_pixel_value i_out_row
//          |          |          | i_out_col i_disp_row i_disp_col
// output   | o_valid  | i_stall  | o_sample_value o_result_row o_result_col
// config   | i_cfg_we | -        | i_cfg_idx i_cfg_data
//
// One item per cycle while o_stall is low; a sample result reaches o_valid through the stage and output registers.
// Six stages: gain multiply, clamp, address and weights, store read, products, sum.
// The store is two copies with two read ports each, so four neighbors read in one cycle.
// Loads write the store in the store-read stage and produce no result.
// An output register plus a skid entry absorb i_stall; o_stall rises only when both fill.
// Reset clears the valid flags and restores the config registers; store contents stay undefined until loaded.
module displacement_warp_bilinear_unit
    import dwb_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_func,
    input  logic [ADDR_W-1:0]       i_load_address,
    input  logic [PIXEL_BITS-1:0]   i_pixel_value,
    input  logic [POS_W-1:0]        i_out_row,
    input  logic [POS_W-1:0]        i_out_col,
    input  logic signed [15:0]      i_disp_row,
    input  logic signed [15:0]      i_disp_col,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [PIXEL_BITS-1:0]   o_sample_value,
    output logic [POS_W-1:0]        o_result_row,
    output logic [POS_W-1:0]        o_result_col,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    logic [SIDE_W-1:0]      r_side_cfg;
    logic [15:0]            r_scale;

    logic                   r_va, r_vb, r_vc, r_vd, r_ve, r_vf;
    logic                   r_sa, r_sb, r_sc;
    logic [ADDR_W-1:0]      r_ld_addr_a, r_ld_addr_b, r_ld_addr_c;
    logic [PIXEL_BITS-1:0]  r_ld_pix_a, r_ld_pix_b, r_ld_pix_c;
    logic [POS_W-1:0]       r_row_a, r_row_b, r_row_c, r_row_d, r_row_e, r_row_f;
    logic [POS_W-1:0]       r_col_a, r_col_b, r_col_c, r_col_d, r_col_e, r_col_f;
    t_quad_addr             r_addr_c;
    t_quad_wgt              r_wgt_c, r_wgt_d;

    logic                   r_ov, r_kv;
    logic [PIXEL_BITS-1:0]  r_out_val, r_sk_val;
    logic [POS_W-1:0]       r_out_row, r_sk_row;
    logic [POS_W-1:0]       r_out_col, r_sk_col;

    logic                   en;
    logic [SIDE_W-1:0]      side;
    t_coord                 crd_row, crd_col;
    t_quad_pix              pix_d;
    logic [PIXEL_BITS-1:0]  value_f;
    logic [10:0]            base_w;
    logic [ADDR_W-1:0]      base;
    logic [ADDR_W-1:0]      side_a;
    t_quad_addr             n_addr;
    logic [FRAC_BITS:0]     wr0, wc0;
    t_quad_wgt              n_wgt;
    logic                   load_out, load_skid;

    assign en      = !r_kv;
    assign o_stall = r_kv;

    always_comb begin
        if (r_side_cfg < SIDE_MIN) begin
            side = SIDE_MIN;
        end else if (r_side_cfg > SIDE_MAX) begin
            side = SIDE_MAX;
        end else begin
            side = r_side_cfg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_cfg <= SIDE_RESET;
            r_scale    <= SCALE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SIDE:  r_side_cfg <= i_cfg_data[SIDE_W-1:0];
                CFG_SCALE: r_scale    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    dwb_coord u_coord_row (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_pos   (i_out_row),
        .i_disp  (i_disp_row),
        .i_scale (r_scale),
        .i_side  (side),
        .o_coord (crd_row)
    );

    dwb_coord u_coord_col (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_pos   (i_out_col),
        .i_disp  (i_disp_col),
        .i_scale (r_scale),
        .i_side  (side),
        .o_coord (crd_col)
    );

    assign base_w  = ({6'b0, crd_col.idx} * {5'b0, side}) + {6'b0, crd_row.idx};
    assign base    = base_w[ADDR_W-1:0];
    assign side_a  = {4'b0, side};
    assign n_addr.ll = base;
    assign n_addr.hl = base + 10'd1;
    assign n_addr.lh = base + side_a;
    assign n_addr.hh = base + side_a + 10'd1;

    assign wr0 = 9'd256 - {1'b0, crd_row.frac};
    assign wc0 = 9'd256 - {1'b0, crd_col.frac};
    assign n_wgt.ll = WGT_W'(wr0) * WGT_W'(wc0);
    assign n_wgt.lh = WGT_W'(wr0) * WGT_W'(crd_col.frac);
    assign n_wgt.hl = WGT_W'(crd_row.frac) * WGT_W'(wc0);
    assign n_wgt.hh = WGT_W'(crd_row.frac) * WGT_W'(crd_col.frac);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
            r_vf <= 1'b0;
        end else if (en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc && (r_sc == FUNC_SAMPLE);
            r_ve <= r_vd;
            r_vf <= r_ve;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sa        <= i_func;
            r_sb        <= r_sa;
            r_sc        <= r_sb;
            r_ld_addr_a <= i_load_address;
            r_ld_addr_b <= r_ld_addr_a;
            r_ld_addr_c <= r_ld_addr_b;
            r_ld_pix_a  <= i_pixel_value;
            r_ld_pix_b  <= r_ld_pix_a;
            r_ld_pix_c  <= r_ld_pix_b;
            r_row_a     <= i_out_row;
            r_row_b     <= r_row_a;
            r_row_c     <= r_row_b;
            r_row_d     <= r_row_c;
            r_row_e     <= r_row_d;
            r_row_f     <= r_row_e;
            r_col_a     <= i_out_col;
            r_col_b     <= r_col_a;
            r_col_c     <= r_col_b;
            r_col_d     <= r_col_c;
            r_col_e     <= r_col_d;
            r_col_f     <= r_col_e;
            r_addr_c    <= n_addr;
            r_wgt_c     <= n_wgt;
            r_wgt_d     <= r_wgt_c;
        end
    end

    dwb_store u_store (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_we    (r_vc && (r_sc == FUNC_LOAD)),
        .i_waddr (r_ld_addr_c),
        .i_wdata (r_ld_pix_c),
        .i_re    (r_vc && (r_sc == FUNC_SAMPLE)),
        .i_raddr (r_addr_c),
        .o_pix   (pix_d)
    );

    dwb_blend u_blend (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_pix   (pix_d),
        .i_wgt   (r_wgt_d),
        .o_value (value_f)
    );

    assign load_out  = en ? (r_vf && (!r_ov || !i_stall)) : !i_stall;
    assign load_skid = en && r_vf && r_ov && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_kv <= 1'b0;
        end else begin
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
            if (load_skid) begin
                r_kv <= 1'b1;
            end else if (!en && !i_stall) begin
                r_kv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            if (en) begin
                r_out_val <= value_f;
                r_out_row <= r_row_f;
                r_out_col <= r_col_f;
            end else begin
                r_out_val <= r_sk_val;
                r_out_row <= r_sk_row;
                r_out_col <= r_sk_col;
            end
        end
        if (load_skid) begin
            r_sk_val <= value_f;
            r_sk_row <= r_row_f;
            r_sk_col <= r_col_f;
        end
    end

    assign o_valid        = r_ov;
    assign o_sample_value = r_out_val;
    assign o_result_row   = r_out_row;
    assign o_result_col   = r_out_col;

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kv |-> r_ov)
        else $error("skid entry held without a valid output register");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_kv && !i_stall) |=> (r_ov && !r_kv))
        else $error("skid entry not moved to output after transfer");

    a_result_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_vf) |=> r_ov)
        else $error("finished sample lost at the output stage");

endmodule
